// ===== rtl/chunked_direct_mapped_cache_slice_assert.svh =====
// assertion macros for the chunked direct-mapped cache slice
// no dependencies; included by files that carry concurrent assertions
`ifndef CHUNKED_DIRECT_MAPPED_CACHE_SLICE_ASSERT_SVH
`define CHUNKED_DIRECT_MAPPED_CACHE_SLICE_ASSERT_SVH

`ifndef SYNTH
`define CDMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cdmc assertion failed");
`define CDMC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cdmc assertion failed during or after reset");
`else
`define CDMC_ASSERT(lbl, clk, rst_n, prop)
`define CDMC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/cdmc_pkg.sv =====
// shared types and constants for the chunked direct-mapped cache slice
// no dependencies
`default_nettype none

package cdmc_pkg;

    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int HOME_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int OFFSET_W   = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_CHUNK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_OFFSET    = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              fill_last;
    } t_request;

    typedef struct packed {
        logic              hit;
        logic              out_of_slice;
        logic [DATA_W-1:0] read_data;
        logic [HOME_W-1:0] home_tile;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/chunked_direct_mapped_cache_slice.sv =====
// chunked direct-mapped cache slice: address mapping, tag and data memories
// depends on cdmc_pkg and chunked_direct_mapped_cache_slice_assert.svh
//
// usage: a command is taken at a rising edge where start is high and busy is
// low. start carries i_req (read word, write word on hit, fill line word).
// the result appears on o_result for exactly one cycle with o_done high; the
// receiver has no way to hold it off, so it must sample on that cycle.
// configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx at once
// (0 lines_per_chunk, 1 slice_offset); write only while busy is low.
// sequence: S_LINE divides the address by LINE_BYTES with a reciprocal
// multiplication; S_SPLIT splits off the word; S_DIV_CHUNK takes the modulo
// by lines_per_chunk with a restoring divider (skipped when it is zero);
// S_HOME divides by NUM_LINES with a reciprocal multiplication; then S_READ
// reads the memories and S_RESP does the read-modify-write. o_done rises in
// the cycle after S_RESP; the next command is taken at the edge that ends the
// o_done cycle. only one command is in flight, so the memories never see
// overlapping accesses to one entry.
// reset: the tag memory holds the valid bits; after reset a clearing pass
// writes NUM_LINES entries, one per cycle, with busy high.
`default_nettype none
`include "chunked_direct_mapped_cache_slice_assert.svh"

module chunked_direct_mapped_cache_slice #(
    parameter int NUM_LINES  = 256,
    parameter int LINE_BYTES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cdmc_pkg::t_request                  i_req,
    output logic                                o_done,
    output cdmc_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [cdmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cdmc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import cdmc_pkg::*;

    localparam int WPL        = (LINE_BYTES + 3) / 4;
    localparam int WORD_W     = (WPL > 1) ? $clog2(WPL) : 1;
    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int DATA_DEPTH = NUM_LINES * WPL;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);
    localparam int LA_W       = 33 - $clog2(LINE_BYTES + 1);
    localparam int DEN_W      = CFG_DATA_W;
    localparam int DIV_CW     = $clog2(ADDR_W);
    localparam int LB_SH      = $clog2(LINE_BYTES);
    localparam int NL_SH      = $clog2(NUM_LINES);
    localparam int RCP_W      = ADDR_W + 1;
    localparam int PROD_W     = ADDR_W + RCP_W;

    // rounded-up reciprocals: (x * rcp) >> (32 + sh) is exact for any 32-bit x
    localparam logic [RCP_W-1:0] LB_RCP = RCP_W'(((64'd1 << (ADDR_W + LB_SH))
                                          + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES));
    localparam logic [RCP_W-1:0] NL_RCP = RCP_W'(((64'd1 << (ADDR_W + NL_SH))
                                          + 64'(NUM_LINES) - 64'd1) / 64'(NUM_LINES));

    localparam logic [DIV_CW-1:0] DIV_LAST  = DIV_CW'(ADDR_W - 1);
    localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(NUM_LINES - 1);

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_LINE      = 3'd2;
    localparam logic [2:0] S_SPLIT     = 3'd3;
    localparam logic [2:0] S_DIV_CHUNK = 3'd4;
    localparam logic [2:0] S_HOME      = 3'd5;
    localparam logic [2:0] S_READ      = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    // control registers
    logic [2:0]            r_state, n_state;
    logic                  r_done, n_done;
    logic [IDX_W-1:0]      r_clr_cnt, n_clr_cnt;
    logic [CFG_DATA_W-1:0] r_lines_per_chunk;
    logic [OFFSET_W-1:0]   r_slice_offset;

    // payload registers
    t_request              r_req, n_req;
    t_result               r_result, n_result;
    logic [ADDR_W-1:0]     r_div_num, n_div_num;
    logic [DEN_W-1:0]      r_div_rem, n_div_rem;
    logic [DEN_W-1:0]      r_div_den, n_div_den;
    logic [DIV_CW-1:0]     r_div_cnt, n_div_cnt;
    logic [LA_W-1:0]       r_line, n_line;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [LA_W-1:0]       r_chunk, n_chunk;
    logic [HOME_W-1:0]     r_home, n_home;
    logic                  r_oos, n_oos;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [DATA_AW-1:0]    r_slot, n_slot;

    // memories
    logic [LA_W:0]         tag_mem [NUM_LINES];
    logic [DATA_W-1:0]     data_mem [DATA_DEPTH];
    logic [LA_W:0]         r_tag_q;
    logic [DATA_W-1:0]     r_data_q;

    logic                  w_mem_re;
    logic                  w_tag_we;
    logic [IDX_W-1:0]      w_tag_addr;
    logic [LA_W:0]         w_tag_wdata;
    logic                  w_data_we;

    // constant divisions
    logic [PROD_W-1:0]     w_line_prod;
    logic [PROD_W-1:0]     w_home_prod;
    logic [ADDR_W-1:0]     w_word_rem;

    // divider step
    logic [DEN_W:0]        w_div_shift;
    logic                  w_div_ge;
    logic [DEN_W-1:0]      w_div_rem;
    logic [ADDR_W-1:0]     w_div_quo;
    logic                  w_div_last;

    // slice window
    logic [ADDR_W-1:0]     w_chunk_ext;
    logic [ADDR_W-1:0]     w_off_ext;
    logic [ADDR_W-1:0]     w_diff;
    logic                  w_oos;
    logic                  w_match;

    assign w_line_prod = PROD_W'(r_req.address) * PROD_W'(LB_RCP);
    assign w_home_prod = PROD_W'(r_chunk) * PROD_W'(NL_RCP);
    assign w_word_rem  = r_req.address - ADDR_W'(r_line) * ADDR_W'(LINE_BYTES);

    assign w_div_shift = {r_div_rem, r_div_num[ADDR_W-1]};
    assign w_div_ge    = w_div_shift >= {1'b0, r_div_den};
    assign w_div_rem   = w_div_ge ? DEN_W'(w_div_shift - {1'b0, r_div_den})
                                  : w_div_shift[DEN_W-1:0];
    assign w_div_quo   = {r_div_num[ADDR_W-2:0], w_div_ge};
    assign w_div_last  = r_div_cnt == DIV_LAST;

    assign w_chunk_ext = ADDR_W'(r_chunk);
    assign w_off_ext   = ADDR_W'(r_slice_offset);
    assign w_diff      = w_chunk_ext - w_off_ext;
    assign w_oos       = (w_chunk_ext < w_off_ext) || (w_diff >= ADDR_W'(NUM_LINES));

    assign w_match     = r_tag_q[LA_W] && (r_tag_q[LA_W-1:0] == r_line);

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_clr_cnt   = r_clr_cnt;
        n_req       = r_req;
        n_result    = r_result;
        n_div_num   = r_div_num;
        n_div_rem   = r_div_rem;
        n_div_den   = r_div_den;
        n_div_cnt   = r_div_cnt;
        n_line      = r_line;
        n_word      = r_word;
        n_chunk     = r_chunk;
        n_home      = r_home;
        n_oos       = r_oos;
        n_idx       = r_idx;
        n_slot      = r_slot;
        w_mem_re    = 1'b0;
        w_tag_we    = 1'b0;
        w_tag_addr  = r_idx;
        w_tag_wdata = {r_req.fill_last, r_line};
        w_data_we   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_tag_we    = 1'b1;
                w_tag_addr  = r_clr_cnt;
                w_tag_wdata = '0;
                n_clr_cnt   = IDX_W'(r_clr_cnt + 1'b1);
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_LINE;
                end
            end
            S_LINE: begin
                n_line  = LA_W'(w_line_prod >> (ADDR_W + LB_SH));
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                n_word    = WORD_W'(w_word_rem >> 2);
                n_div_num = ADDR_W'(r_line);
                n_div_rem = '0;
                n_div_cnt = '0;
                if (r_lines_per_chunk == '0) begin
                    // no chunking: the chunk index is the line address
                    n_chunk = r_line;
                    n_state = S_HOME;
                end else begin
                    n_div_den = r_lines_per_chunk;
                    n_state   = S_DIV_CHUNK;
                end
            end
            S_DIV_CHUNK: begin
                n_div_num = w_div_quo;
                n_div_rem = w_div_rem;
                n_div_cnt = DIV_CW'(r_div_cnt + 1'b1);
                if (w_div_last) begin
                    n_chunk = LA_W'(w_div_rem);
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                n_home  = HOME_W'(w_home_prod >> (ADDR_W + NL_SH));
                n_oos   = w_oos;
                n_idx   = w_diff[IDX_W-1:0];
                n_slot  = DATA_AW'(DATA_AW'(w_diff[IDX_W-1:0]) * DATA_AW'(WPL)
                                   + DATA_AW'(r_word));
                n_state = S_READ;
            end
            S_READ: begin
                w_mem_re = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                n_result.hit          = 1'b0;
                n_result.out_of_slice = r_oos;
                n_result.read_data    = '0;
                n_result.home_tile    = r_home;
                if (!r_oos) begin
                    unique case (r_req.command)
                        CMD_READ: begin
                            n_result.hit       = w_match;
                            n_result.read_data = w_match ? r_data_q : '0;
                        end
                        CMD_WRITE: begin
                            n_result.hit = w_match;
                            w_data_we    = w_match;
                        end
                        CMD_FILL: begin
                            // valid only comes back with the last word
                            w_data_we = 1'b1;
                            w_tag_we  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_done    <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_per_chunk <= CFG_DATA_W'(256);
            r_slice_offset    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINES_PER_CHUNK: r_lines_per_chunk <= i_cfg_wdata;
                CFG_SLICE_OFFSET:    r_slice_offset    <= i_cfg_wdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_result  <= n_result;
        r_div_num <= n_div_num;
        r_div_rem <= n_div_rem;
        r_div_den <= n_div_den;
        r_div_cnt <= n_div_cnt;
        r_line    <= n_line;
        r_word    <= n_word;
        r_chunk   <= n_chunk;
        r_home    <= n_home;
        r_oos     <= n_oos;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
    end

    // tag memory: {valid, line address}
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            tag_mem[w_tag_addr] <= w_tag_wdata;
        end
        if (w_mem_re) begin
            r_tag_q <= tag_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            data_mem[r_slot] <= r_req.write_data;
        end
        if (w_mem_re) begin
            r_data_q <= data_mem[r_slot];
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_result;

    `CDMC_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done)
    `CDMC_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy)
    `CDMC_ASSERT(a_oos_quiet, i_clk, i_rst_n, (o_done && o_result.out_of_slice) |-> (!o_result.hit && o_result.read_data == '0))
    `CDMC_ASSERT(a_data_we_resp, i_clk, i_rst_n, w_data_we |-> (r_state == S_RESP && !r_oos))
    `CDMC_ASSERT(a_fill_tag, i_clk, i_rst_n, (r_state == S_RESP && !r_oos && r_req.command == CMD_FILL) |-> w_tag_we)
    `CDMC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR && !o_done))

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for chunked_direct_mapped_cache_slice
// depends on cdmc_pkg and the slice rtl; a shadow cache predicts all results but those of typed directed rows

module testbench;
    import cdmc_pkg::*;

    localparam int NUM_LINES      = 256;
    localparam int LINE_BYTES     = 32;
    localparam int WORDS_PER_LINE = LINE_BYTES / 4;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASE_ITEMS    = 305;

    typedef struct {
        logic [26:0] line;
        logic [31:0] chunk;
        logic [7:0]  idx;
        int          slot;
        bit          outside;
        logic [7:0]  home;
    } t_mapping;

    typedef struct {
        t_request req;
        bit       typed;
        t_result  want;
    } t_directed_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_request        req_bus = '0;
    logic            done;
    t_result         result_bus;
    logic            cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow copy of the slice state and its registers
    bit              shadow_valid [NUM_LINES];
    logic [26:0]     shadow_tag   [NUM_LINES];
    logic [31:0]     shadow_data  [NUM_LINES*WORDS_PER_LINE];
    bit              word_written [NUM_LINES*WORDS_PER_LINE];
    logic [16:0]     cfg_lines_per_chunk = 17'd256;
    logic [15:0]     cfg_slice_offset = 16'd0;

    t_result         expected_lookups [$];
    t_result         oldest_lookup;
    t_directed_row   directed_rows [$];
    logic [26:0]     filled_lines [$];
    int              items_sent = 0;
    int              errors = 0;
    int              cycle_count = 0;
    bit              idle_enabled = 1'b1;

    chunked_direct_mapped_cache_slice #(
        .NUM_LINES  (NUM_LINES),
        .LINE_BYTES (LINE_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req_bus),
        .o_done      (done),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[chunked_direct_mapped_cache_slice] ERROR");
            $finish;
        end
    end

    function automatic t_mapping map_address(logic [31:0] address);
        t_mapping m;
        m.line = address[31:5];
        m.chunk = (cfg_lines_per_chunk != 0) ? {5'b0, m.line} % cfg_lines_per_chunk
                                             : {5'b0, m.line};
        m.home = 8'(m.chunk / NUM_LINES);
        m.outside = (m.chunk < cfg_slice_offset) ||
                    (m.chunk - cfg_slice_offset >= NUM_LINES);
        m.idx = 8'(m.chunk - cfg_slice_offset);
        m.slot = int'(m.idx) * WORDS_PER_LINE + int'(address[4:2]);
        return m;
    endfunction

    function automatic bit line_hit(t_mapping m);
        return !m.outside && shadow_valid[m.idx] && shadow_tag[m.idx] == m.line;
    endfunction

    function automatic t_result access_shadow_cache(t_request req);
        t_mapping m;
        t_result  r;
        m = map_address(req.address);
        r = '0;
        r.out_of_slice = m.outside;
        r.home_tile = m.home;
        if (!m.outside) begin
            case (req.command)
                CMD_READ: begin
                    if (line_hit(m)) begin
                        r.hit = 1'b1;
                        r.read_data = shadow_data[m.slot];
                    end
                end
                CMD_WRITE: begin
                    if (line_hit(m)) begin
                        r.hit = 1'b1;
                        shadow_data[m.slot] = req.write_data;
                        word_written[m.slot] = 1'b1;
                    end
                end
                CMD_FILL: begin
                    shadow_data[m.slot] = req.write_data;
                    word_written[m.slot] = 1'b1;
                    shadow_valid[m.idx] = req.fill_last;
                    if (req.fill_last)
                        shadow_tag[m.idx] = m.line;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // random line inside the current window, sometimes crowded onto few aliases
    function automatic logic [26:0] window_line();
        logic [31:0] chunk;
        logic [31:0] span;
        chunk = cfg_slice_offset + $urandom_range(0, NUM_LINES - 1);
        if (cfg_lines_per_chunk == 0)
            return chunk[26:0];
        span = (32'h07FF_FFFF - chunk) / cfg_lines_per_chunk;
        if ($urandom_range(0, 1) && span > 3)
            span = 3;
        return 27'($urandom_range(0, span) * cfg_lines_per_chunk + chunk);
    endfunction

    function automatic logic [31:0] line_address(logic [26:0] line, logic [2:0] word);
        return {line, word, 2'($urandom_range(0, 3))};
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_request(input t_request req, input bit typed, input t_result want);
        t_result  predicted;
        t_mapping m;
        m = map_address(req.address);
        // a read hit must never land on a word that was never stored
        if (!typed && req.command == CMD_READ && line_hit(m) && !word_written[m.slot])
            req.command = CMD_WRITE;
        start = 1'b1;
        req_bus = req;
        do @(posedge i_clk); while (busy);
        predicted = access_shadow_cache(req);
        expected_lookups.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) begin
                do @(posedge i_clk); while (busy);
                @(negedge i_clk);
            end
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_lookups.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_wdata = value;
        @(posedge i_clk);
        if (idx == CFG_LINES_PER_CHUNK)
            cfg_lines_per_chunk = value;
        else
            cfg_slice_offset = value[15:0];
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_row(input logic [CMD_W-1:0] command, input logic [31:0] address,
                           input logic [31:0] data, input bit last, input bit typed,
                           input bit hit, input bit outside, input logic [31:0] rdata,
                           input logic [7:0] home);
        t_directed_row row;
        row.req = '{command: command, address: address, write_data: data, fill_last: last};
        row.typed = typed;
        row.want = '{hit: hit, out_of_slice: outside, read_data: rdata, home_tile: home};
        directed_rows.push_back(row);
    endtask

    task automatic run_phase(input int count);
        int       target;
        int       pick;
        int       last_word;
        bit       paused;
        t_request r;
        logic [26:0] line;
        target = items_sent + count;
        paused = 1'b0;
        filled_lines.delete();
        while (items_sent < target) begin
            if (!paused && items_sent >= target - count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // line fill, occasionally broken: early last or no last at all
                line = window_line();
                last_word = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 7;
                for (int w = 0; w < WORDS_PER_LINE; w++) begin
                    r.command = CMD_FILL;
                    r.address = line_address(line, 3'(w));
                    r.write_data = $urandom;
                    r.fill_last = (w == last_word);
                    send_request(r, 1'b0, '0);
                end
                if (last_word == 7) begin
                    filled_lines.push_back(line);
                    if (filled_lines.size() > 16)
                        void'(filled_lines.pop_front());
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    line = (filled_lines.size() != 0)
                         ? filled_lines[$urandom_range(0, filled_lines.size() - 1)]
                         : window_line();
                    r.command = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
                    r.address = line_address(line, 3'($urandom_range(0, 7)));
                    r.write_data = $urandom;
                    r.fill_last = 1'($urandom_range(0, 1));
                    send_request(r, 1'b0, '0);
                end
            end else if (pick < 90) begin
                r.command = CMD_W'($urandom_range(0, 2));
                r.address = line_address(window_line(), 3'($urandom_range(0, 7)));
                r.write_data = $urandom;
                r.fill_last = 1'($urandom_range(0, 1));
                send_request(r, 1'b0, '0);
            end else begin
                r.command = CMD_W'($urandom_range(0, 3));
                r.address = $urandom;
                r.write_data = $urandom;
                r.fill_last = 1'($urandom_range(0, 1));
                send_request(r, 1'b0, '0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && done) begin
            if (expected_lookups.size() == 0) begin
                $error("unexpected result transaction: hit %0d out_of_slice %0d data %h",
                       result_bus.hit, result_bus.out_of_slice, result_bus.read_data);
                errors++;
            end else begin
                oldest_lookup = expected_lookups.pop_front();
                if (result_bus.hit !== oldest_lookup.hit) begin
                    $error("hit: expected %0d, got %0d", oldest_lookup.hit, result_bus.hit);
                    errors++;
                end
                if (result_bus.out_of_slice !== oldest_lookup.out_of_slice) begin
                    $error("out_of_slice: expected %0d, got %0d",
                           oldest_lookup.out_of_slice, result_bus.out_of_slice);
                    errors++;
                end
                if (result_bus.read_data !== oldest_lookup.read_data) begin
                    $error("read_data: expected %h, got %h",
                           oldest_lookup.read_data, result_bus.read_data);
                    errors++;
                end
                if (result_bus.home_tile !== oldest_lookup.home_tile) begin
                    $error("home_tile: expected %0d, got %0d",
                           oldest_lookup.home_tile, result_bus.home_tile);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_config(CFG_LINES_PER_CHUNK, 17'd256);
        write_config(CFG_SLICE_OFFSET, 17'd0);

        // cold misses, address extremes and the unused command
        add_row(CMD_READ,   32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 32'h0, 8'd0);
        add_row(CMD_WRITE,  32'h0000_0020, 32'hFFFF_FFFF, 1'b0, 1, 0, 0, 32'h0, 8'd0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 32'h0, 8'd0);
        // full fill of line 5, last flag on the final word
        for (int w = 0; w < WORDS_PER_LINE; w++)
            add_row(CMD_FILL, 32'h0000_00A0 + 4 * w, (w == 0) ? 32'hFFFF_FFFF : 32'h1111_1111 * w,
                    w == WORDS_PER_LINE - 1, 1, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_00A0, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_00BF, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_WRITE, 32'h0000_00A4, 32'h0, 1'b1, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_00A4, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        // alias of line 5 in the next chunk: miss, then a fill without last drops valid
        add_row(CMD_READ,  32'h0000_20A0, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_FILL,  32'h0000_20A0, 32'hDEAD_BEEF, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_00A0, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_FILL,  32'h0000_20A0, 32'h0BAD_F00D, 1'b1, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_20BC, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_WRITE, 32'h0000_00A8, 32'h1234_5678, 1'b0, 0, 0, 0, 32'h0, 8'd0);
        add_row(CMD_READ,  32'h0000_20A0, 32'h0, 1'b0, 0, 0, 0, 32'h0, 8'd0);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        run_phase(PHASE_ITEMS);

        // zero chunk size: the chunk index is the whole line address
        write_config(CFG_LINES_PER_CHUNK, 17'd0);
        write_config(CFG_SLICE_OFFSET, 17'h1234);
        run_phase(PHASE_ITEMS);

        // chunk of 65536 lines with the slice at its top end
        write_config(CFG_LINES_PER_CHUNK, 17'd65536);
        write_config(CFG_SLICE_OFFSET, 17'd65280);
        run_phase(PHASE_ITEMS);

        write_config(CFG_LINES_PER_CHUNK, 17'h1FFFF);
        write_config(CFG_SLICE_OFFSET, 17'hFFFF);
        run_phase(PHASE_ITEMS);

        // chunk size that is not a multiple of the slice
        write_config(CFG_LINES_PER_CHUNK, 17'd300);
        write_config(CFG_SLICE_OFFSET, 17'd44);
        run_phase(PHASE_ITEMS);

        write_config(CFG_LINES_PER_CHUNK, 17'd1024);
        write_config(CFG_SLICE_OFFSET, 17'd768);
        idle_enabled = 1'b0;
        run_phase(PHASE_ITEMS);

        wait_drained();
        repeat (120) @(posedge i_clk);
        if (errors == 0 && expected_lookups.size() == 0)
            $display("[chunked_direct_mapped_cache_slice] OK");
        else
            $display("[chunked_direct_mapped_cache_slice] ERROR");
        $finish;
    end

endmodule
